// ----- rtl/core/akit_pkg.sv -----
// Package for the angle knob increment tracker.
// Holds field widths, fixed constants, op codes and the struct types shared by
// akit_step and angle_knob_increment_tracker. No dependencies.
package akit_pkg;

  // Fixed widths of the item fields
  localparam int KNOB_W  = 3;
  localparam int ANGLE_W = 12;
  localparam int VALUE_W = 7;
  localparam int TICK_W  = 8;

  // Knob value limit
  localparam logic [VALUE_W-1:0] VALUE_MAX = 7'd127;

  // Item operation codes
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  // Control bits handed to the per-knob update logic
  typedef struct packed {
    op_e  op;
    logic hold;
    logic enable;
    logic seeded;
  } step_ctl_t;

  // Per-knob update result (value, flags and the new seeded bit)
  typedef struct packed {
    logic [VALUE_W-1:0]       value;
    logic                     changed;
    logic signed [TICK_W-1:0] ticks;
    logic                     seeded;
  } step_res_t;

endpackage

// ----- rtl/core/akit_step.sv -----
// Per-knob update logic of the angle knob increment tracker.
// Purely combinational: takes one item plus the addressed knob's state and
// returns the new state and the result fields. Uses akit_pkg.
module akit_step #(
  parameter int ANGLE_BITS = 12
) (
  input  akit_pkg::step_ctl_t              ctl_i,
  input  logic [ANGLE_BITS-1:0]            angle_i,
  input  logic [akit_pkg::VALUE_W-1:0]     load_value_i,
  input  logic [ANGLE_BITS-1:0]            last_angle_i,
  input  logic signed [ANGLE_BITS:0]       motion_sum_i,
  input  logic [akit_pkg::VALUE_W-1:0]     value_i,
  output akit_pkg::step_res_t              res_o,
  output logic [ANGLE_BITS-1:0]            last_angle_o,
  output logic signed [ANGLE_BITS:0]       motion_sum_o
);

  // Working width: enough for a full turn plus sign and headroom
  localparam int SW = ANGLE_BITS + 2;
  localparam int US = ANGLE_BITS - 7;
  localparam logic signed [SW-1:0] HalfTurn  = SW'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [SW-1:0] TurnCnt   = SW'(2 ** ANGLE_BITS);
  localparam logic [SW-1:0]        TwoUnits  = SW'(2 ** (US + 1));

  logic signed [SW-1:0]                raw_d;
  logic signed [SW-1:0]                delta;
  logic signed [SW-1:0]                mv;
  logic signed [SW-1:0]                acc_base;
  logic signed [SW-1:0]                acc_sum;
  logic [SW-1:0]                       mag;
  logic [akit_pkg::TICK_W-1:0]         whole;
  logic signed [akit_pkg::TICK_W-1:0]  tick_sig;
  logic signed [SW-1:0]                acc_rem;
  logic signed [akit_pkg::VALUE_W+1:0] nv;
  logic [akit_pkg::VALUE_W-1:0]        nv_clamp;
  logic                                at_lim_hi;
  logic                                at_lim_lo;

  // Wrapped, negated angle delta (clockwise is positive)
  always_comb begin
    raw_d = $signed({2'b00, angle_i}) - $signed({2'b00, last_angle_i});
    delta = raw_d;
    if (raw_d > HalfTurn) begin
      delta = raw_d - TurnCnt;
    end else if (raw_d < -HalfTurn) begin
      delta = raw_d + TurnCnt;
    end
    mv = -delta;
  end

  // Accumulate, with the reversal-at-limit clear
  always_comb begin
    at_lim_hi = (value_i == akit_pkg::VALUE_MAX) && mv[SW-1] && (motion_sum_i > 0);
    at_lim_lo = (value_i == '0) && !mv[SW-1] && (mv != '0) && motion_sum_i[ANGLE_BITS];
    acc_base  = (at_lim_hi || at_lim_lo) ? '0 : SW'(motion_sum_i);
    acc_sum   = acc_base + mv;
    mag       = acc_sum[SW-1] ? SW'(-acc_sum) : SW'(acc_sum);
  end

  // Whole ticks truncated toward zero; the remainder keeps the sign
  always_comb begin
    whole    = akit_pkg::TICK_W'(mag >> US);
    tick_sig = acc_sum[SW-1] ? -$signed(whole) : $signed(whole);
    acc_rem  = acc_sum[SW-1] ? -$signed(SW'(mag[US-1:0])) : $signed(SW'(mag[US-1:0]));
    nv       = $signed({2'b00, value_i}) +
               $signed({tick_sig[akit_pkg::TICK_W-1], tick_sig});
    if (nv < 0) begin
      nv_clamp = '0;
    end else if (nv > $signed({3'b000, akit_pkg::VALUE_MAX})) begin
      nv_clamp = akit_pkg::VALUE_MAX;
    end else begin
      nv_clamp = nv[akit_pkg::VALUE_W-1:0];
    end
  end

  // Item decode and state update
  always_comb begin
    res_o.value   = value_i;
    res_o.ticks   = '0;
    res_o.seeded  = ctl_i.seeded;
    last_angle_o  = last_angle_i;
    motion_sum_o  = motion_sum_i;
    if (ctl_i.op == akit_pkg::OP_LOAD) begin
      res_o.value  = load_value_i;
      res_o.seeded = 1'b0;
      motion_sum_o = '0;
    end else if (ctl_i.enable) begin
      last_angle_o = angle_i;
      if (!ctl_i.seeded) begin
        res_o.seeded = 1'b1;
        motion_sum_o = '0;
      end else if (ctl_i.hold) begin
        motion_sum_o = '0;
      end else if (mag >= TwoUnits) begin
        res_o.ticks = tick_sig;
        res_o.value = nv_clamp;
        if (nv_clamp == '0 || nv_clamp == akit_pkg::VALUE_MAX) begin
          motion_sum_o = '0;
        end else begin
          motion_sum_o = acc_rem[ANGLE_BITS:0];
        end
      end else begin
        motion_sum_o = acc_sum[ANGLE_BITS:0];
      end
    end
    res_o.changed = (res_o.value != value_i);
  end

endmodule

// ----- rtl/core/angle_knob_increment_tracker.sv -----
// Angle knob increment tracker: absolute knob angles in, 0..127 knob values out.
// Item, then result, registered; per-knob state is a flip-flop read-modify-write.
// Throughput: 1 item per cycle unless a full result register is blocked.
// Reset (rst_ni low, async): enable off, all knobs unseeded, values and sums zero.
// Depends on akit_pkg and akit_step.
module angle_knob_increment_tracker #(
  parameter int KNOBS      = 6,
  parameter int ANGLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_enable_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [akit_pkg::KNOB_W-1:0]         knob_i,
  input  logic [akit_pkg::ANGLE_W-1:0]        angle_i,
  input  logic [akit_pkg::VALUE_W-1:0]        load_value_i,
  input  logic                                hold_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [akit_pkg::KNOB_W-1:0]         knob_out_o,
  output logic [akit_pkg::VALUE_W-1:0]        value_o,
  output logic                                changed_o,
  output logic signed [akit_pkg::TICK_W-1:0]  ticks_o
);

  localparam int KW = (KNOBS > 1) ? $clog2(KNOBS) : 1;

  // Configuration
  logic enable_q;

  // Input register
  logic                         in_valid_q;
  akit_pkg::op_e                op_q;
  logic [akit_pkg::KNOB_W-1:0]  knob_q;
  logic [ANGLE_BITS-1:0]        angle_q;
  logic [akit_pkg::VALUE_W-1:0] load_q;
  logic                         hold_q;

  // Per-knob state
  logic                         seeded_q     [KNOBS];
  logic [ANGLE_BITS-1:0]        last_angle_q [KNOBS];
  logic signed [ANGLE_BITS:0]   motion_sum_q [KNOBS];
  logic [akit_pkg::VALUE_W-1:0] knob_value_q [KNOBS];

  // Result register
  logic                                out_valid_q;
  logic [akit_pkg::KNOB_W-1:0]         knob_out_q;
  logic [akit_pkg::VALUE_W-1:0]        value_q;
  logic                                changed_q;
  logic signed [akit_pkg::TICK_W-1:0]  ticks_q;

  logic                       advance;
  logic                       in_range;
  logic [KW-1:0]              idx;
  akit_pkg::step_ctl_t        ctl;
  akit_pkg::step_res_t        res;
  logic [ANGLE_BITS-1:0]      last_angle_d;
  logic signed [ANGLE_BITS:0] motion_sum_d;
  logic                       state_we;
  logic                       en_rise;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || !out_valid_q || out_ready_i;
  assign en_rise     = cfg_valid_i && cfg_enable_i && !enable_q;

  // Enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      enable_q <= cfg_enable_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= akit_pkg::op_e'(op_i);
      knob_q  <= knob_i;
      angle_q <= ANGLE_BITS'(angle_i);
      load_q  <= load_value_i;
      hold_q  <= hold_i;
    end
  end

  // Knob select
  assign in_range = (5'(knob_q) < 5'(KNOBS));
  assign idx      = in_range ? KW'(knob_q) : '0;
  assign state_we = advance && in_range;

  assign ctl.op     = op_q;
  assign ctl.hold   = hold_q;
  assign ctl.enable = enable_q;
  assign ctl.seeded = seeded_q[idx];

  akit_step #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_step (
    .ctl_i        (ctl),
    .angle_i      (angle_q),
    .load_value_i (load_q),
    .last_angle_i (last_angle_q[idx]),
    .motion_sum_i (motion_sum_q[idx]),
    .value_i      (knob_value_q[idx]),
    .res_o        (res),
    .last_angle_o (last_angle_d),
    .motion_sum_o (motion_sum_d)
  );

  // Per-knob state write-back; enable rising unseeds every knob
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KNOBS; i++) begin
        seeded_q[i]     <= 1'b0;
        motion_sum_q[i] <= '0;
        knob_value_q[i] <= '0;
      end
    end else begin
      if (state_we) begin
        motion_sum_q[idx] <= motion_sum_d;
        knob_value_q[idx] <= res.value;
      end
      for (int i = 0; i < KNOBS; i++) begin
        if (en_rise) begin
          seeded_q[i] <= 1'b0;
        end else if (state_we && (idx == KW'(i))) begin
          seeded_q[i] <= res.seeded;
        end
      end
    end
  end

  // Reference angles are only read after being written
  always_ff @(posedge clk_i) begin
    if (state_we) begin
      last_angle_q[idx] <= last_angle_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      knob_out_q <= knob_q;
      value_q    <= in_range ? res.value   : '0;
      changed_q  <= in_range ? res.changed : 1'b0;
      ticks_q    <= in_range ? res.ticks   : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign knob_out_o  = knob_out_q;
  assign value_o     = value_q;
  assign changed_o   = changed_q;
  assign ticks_o     = ticks_q;

`ifndef SYNTHESIS
  // Input side only stalls behind a full, blocked result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // Ticks that leave the value unchanged only happen at a limit
  a_ticks_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ticks_o != '0) && !changed_o |->
      (value_o == '0) || (value_o == akit_pkg::VALUE_MAX))
    else $error("ticks applied but value unchanged away from a limit");

  // Knobs out of range report zeros
  a_bad_knob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (5'(knob_out_o) >= 5'(KNOBS)) |->
      (value_o == '0) && !changed_o && (ticks_o == '0))
    else $error("out-of-range knob produced a nonzero result");

  // Stored motion stays below two units in magnitude
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_we |->
      (motion_sum_d < $signed((ANGLE_BITS + 1)'(2 ** (ANGLE_BITS - 6)))) &&
      (motion_sum_d > -$signed((ANGLE_BITS + 1)'(2 ** (ANGLE_BITS - 6)))))
    else $error("motion sum out of bounds");
`endif

endmodule

// ----- tb/tb_angle_knob_increment_tracker.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for angle_knob_increment_tracker: directed and random angle
// samples and loads under random idling, with a per-item knob value predictor.
// Depends on akit_pkg and the tracker RTL.
module tb_angle_knob_increment_tracker;

  localparam int KNOBS        = 6;
  localparam int ANGLE_BITS   = 12;
  localparam int TURN_COUNTS  = 1 << ANGLE_BITS;
  localparam int HALF_TURN    = TURN_COUNTS / 2;
  localparam int UNIT_SHIFT   = ANGLE_BITS - 7;
  localparam int UNIT_COUNTS  = 1 << UNIT_SHIFT;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [akit_pkg::KNOB_W-1:0]        knob;
    logic [akit_pkg::VALUE_W-1:0]       value;
    logic                               changed;
    logic signed [akit_pkg::TICK_W-1:0] ticks;
  } knob_result_t;

  // Knob state mirror plus the queue of results still owed by the block
  class knob_value_scoreboard;
    bit                           enable;
    bit                           seeded[KNOBS];
    logic [akit_pkg::ANGLE_W-1:0] last_angle[KNOBS];
    int                           motion_sum[KNOBS];
    logic [akit_pkg::VALUE_W-1:0] knob_value[KNOBS];
    knob_result_t                 owed_results[$];
    int                           errors;

    function new();
      enable = 1'b0;
      errors = 0;
      for (int i = 0; i < KNOBS; i++) begin
        seeded[i]     = 1'b0;
        last_angle[i] = '0;
        motion_sum[i] = 0;
        knob_value[i] = '0;
      end
    endfunction

    // A rising enable forces every knob to reseed
    function void set_enable(bit en);
      if (en && !enable) begin
        for (int i = 0; i < KNOBS; i++) seeded[i] = 1'b0;
      end
      enable = en;
    endfunction

    // Update the mirror for one accepted item and queue the result it causes
    function void track_item(akit_pkg::op_e op, logic [akit_pkg::KNOB_W-1:0] k,
                             logic [akit_pkg::ANGLE_W-1:0] ang,
                             logic [akit_pkg::VALUE_W-1:0] ld, logic hold);
      knob_result_t res;
      logic [akit_pkg::VALUE_W-1:0] prior;
      int delta, mv, acc, mag, whole, nv, ticks;
      ticks = 0;
      res.knob = k;
      res.value = '0;
      res.changed = 1'b0;
      res.ticks = '0;
      if (k < KNOBS) begin
        prior = knob_value[k];
        if (op == akit_pkg::OP_LOAD) begin
          knob_value[k] = ld;
          seeded[k]     = 1'b0;
          motion_sum[k] = 0;
        end else if (enable) begin
          if (!seeded[k]) begin
            seeded[k]     = 1'b1;
            last_angle[k] = ang;
            motion_sum[k] = 0;
          end else begin
            delta = (int'(ang) & (TURN_COUNTS - 1)) - int'(last_angle[k]);
            last_angle[k] = ang;
            // wrap into +-half turn; exactly half a turn stays as it is
            if (delta > HALF_TURN) delta -= TURN_COUNTS;
            if (delta < -HALF_TURN) delta += TURN_COUNTS;
            mv = -delta;
            if (hold) begin
              motion_sum[k] = 0;
            end else begin
              acc = motion_sum[k];
              // backing off a limit drops motion stored against it
              if ((knob_value[k] == akit_pkg::VALUE_MAX && mv < 0 && acc > 0) ||
                  (knob_value[k] == 0 && mv > 0 && acc < 0))
                acc = 0;
              acc += mv;
              mag = (acc < 0) ? -acc : acc;
              if (mag >= 2 * UNIT_COUNTS) begin
                whole = mag >> UNIT_SHIFT;
                ticks = (acc < 0) ? -whole : whole;
                acc -= ticks * UNIT_COUNTS;
                nv = int'(knob_value[k]) + ticks;
                if (nv < 0) nv = 0;
                if (nv > int'(akit_pkg::VALUE_MAX)) nv = int'(akit_pkg::VALUE_MAX);
                knob_value[k] = akit_pkg::VALUE_W'(nv);
                if (nv == 0 || nv == int'(akit_pkg::VALUE_MAX)) acc = 0;
              end
              motion_sum[k] = acc;
            end
          end
        end
        res.value   = knob_value[k];
        res.changed = (knob_value[k] != prior);
        res.ticks   = akit_pkg::TICK_W'(ticks);
      end
      owed_results.push_back(res);
    endfunction

    function void check_result(knob_result_t got);
      knob_result_t want;
      if (owed_results.size() == 0) begin
        $error("result item with no item pending: knob_out %0d value %0d", got.knob,
               got.value);
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (got.knob !== want.knob) begin
          $error("knob_out: expected %0d, got %0d", want.knob, got.knob);
          errors++;
        end
        if (got.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, got.value);
          errors++;
        end
        if (got.changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, got.changed);
          errors++;
        end
        if (got.ticks !== want.ticks) begin
          $error("ticks: expected %0d, got %0d", want.ticks, got.ticks);
          errors++;
        end
      end
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic                               cfg_enable_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic                               op_i;
  logic [akit_pkg::KNOB_W-1:0]        knob_i;
  logic [akit_pkg::ANGLE_W-1:0]       angle_i;
  logic [akit_pkg::VALUE_W-1:0]       load_value_i;
  logic                               hold_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [akit_pkg::KNOB_W-1:0]        knob_out_o;
  logic [akit_pkg::VALUE_W-1:0]       value_o;
  logic                               changed_o;
  logic signed [akit_pkg::TICK_W-1:0] ticks_o;

  knob_value_scoreboard tracker = new();

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int ready_holdoff      = 0;
  int cycle_count        = 0;

  // Per-knob angle walk used to build realistic turning sequences
  logic [akit_pkg::ANGLE_W-1:0] knob_angle[KNOBS];
  int                           knob_dir[KNOBS];

  angle_knob_increment_tracker #(
    .KNOBS      (KNOBS),
    .ANGLE_BITS (ANGLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_enable_i (cfg_enable_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .knob_i       (knob_i),
    .angle_i      (angle_i),
    .load_value_i (load_value_i),
    .hold_i       (hold_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .knob_out_o   (knob_out_o),
    .value_o      (value_o),
    .changed_o    (changed_o),
    .ticks_o      (ticks_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_angle_knob_increment_tracker: errors");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (ready_holdoff > 0) begin
        out_ready_i <= 1'b0;
        ready_holdoff--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(knob_result_t'{knob_out_o, value_o, changed_o, ticks_o});
  end

  // Offer one item, called at a falling edge; returns at the falling edge after accept
  task automatic send_item(akit_pkg::op_e op, logic [akit_pkg::KNOB_W-1:0] k,
                           logic [akit_pkg::ANGLE_W-1:0] ang,
                           logic [akit_pkg::VALUE_W-1:0] ld, logic hold);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    knob_i       <= k;
    angle_i      <= ang;
    load_value_i <= ld;
    hold_i       <= hold;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.track_item(op, k, ang, ld, hold);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.owed_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_enable(logic en);
    cfg_valid_i  <= 1'b1;
    cfg_enable_i <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_enable(en);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly turning sequences; some jumps, loads and out-of-range knobs
  task automatic send_random_item();
    int unsigned                  pick;
    int                           step;
    akit_pkg::op_e                op;
    logic [akit_pkg::KNOB_W-1:0]  k;
    logic [akit_pkg::ANGLE_W-1:0] ang;
    logic [akit_pkg::VALUE_W-1:0] ld;
    logic                         hold;
    pick = $urandom_range(99);
    op   = akit_pkg::OP_SAMPLE;
    k    = akit_pkg::KNOB_W'($urandom_range(KNOBS - 1));
    ang  = akit_pkg::ANGLE_W'($urandom);
    ld   = akit_pkg::VALUE_W'($urandom);
    hold = ($urandom_range(15) == 0);
    if (pick < 4) begin
      op = akit_pkg::OP_LOAD;
      if ($urandom_range(2) == 0) ld = $urandom_range(1) ? akit_pkg::VALUE_MAX : '0;
    end else if (pick < 7) begin
      k  = akit_pkg::KNOB_W'($urandom_range(7, KNOBS));
      op = akit_pkg::op_e'($urandom_range(1));
    end else if (pick >= 12) begin
      if ($urandom_range(19) == 0) knob_dir[k] = -knob_dir[k];
      step = knob_dir[k] * (int'($urandom_range(120)) - 40);
      ang  = knob_angle[k] + akit_pkg::ANGLE_W'(step);
    end
    if (op == akit_pkg::OP_SAMPLE && k < KNOBS) knob_angle[k] = ang;
    send_item(op, k, ang, ld, hold);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) send_random_item();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_enable_i = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = akit_pkg::OP_SAMPLE;
    knob_i       = '0;
    angle_i      = '0;
    load_value_i = '0;
    hold_i       = 1'b0;
    for (int i = 0; i < KNOBS; i++) begin
      knob_angle[i] = '0;
      knob_dir[i]   = 1;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Disabled: samples change nothing, loads still apply, bad knobs report zeros
    write_enable(1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'hFFF, 7'd0, 1'b1);
    send_item(akit_pkg::OP_LOAD,   3'd7, 12'h000, 7'd127, 1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd6, 12'h000, 7'd0, 1'b0);
    send_item(akit_pkg::OP_LOAD,   3'd2, 12'h000, 7'd0, 1'b0);
    drain();
    write_enable(1'b1);

    // Seed, exact half turns both ways, wrap, hold, landing on both limits
    send_item(akit_pkg::OP_LOAD,   3'd0, 12'd0,    7'd64, 1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd0,    7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd2048, 7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd0,    7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd4095, 7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd4000, 7'd0,  1'b1);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd1952, 7'd0,  1'b0);
    // reversal at the top limit
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd1912, 7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd0, 12'd1922, 7'd0,  1'b0);
    // reversal at the bottom limit
    send_item(akit_pkg::OP_LOAD,   3'd1, 12'd0,    7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd1, 12'd1000, 7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd1, 12'd1040, 7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd1, 12'd1030, 7'd0,  1'b0);
    // largest tick counts, up and down
    send_item(akit_pkg::OP_LOAD,   3'd3, 12'd0,    7'd50, 1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd3, 12'd0,    7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd3, 12'd4033, 7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd3, 12'd1985, 7'd0,  1'b0);
    send_item(akit_pkg::OP_LOAD,   3'd4, 12'd0,    7'd100, 1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd4, 12'd0,    7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd4, 12'd63,   7'd0,  1'b0);
    send_item(akit_pkg::OP_SAMPLE, 3'd4, 12'd2111, 7'd0,  1'b0);
    drain();

    // Random traffic across idling mixes and enable settings
    run_phase(180, 0, 0);
    run_phase(180, 49, 0);
    run_phase(180, 0, 49);
    drain();
    write_enable(1'b1);
    run_phase(100, 11, 11);
    drain();
    write_enable(1'b0);
    run_phase(30, 11, 11);
    drain();
    write_enable(1'b1);
    run_phase(80, 11, 11);

    // Long result hold-off so the block backs up and stalls its input
    ready_holdoff = 300;
    run_phase(50, 0, 0);

    drain();
    if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
      $display("tb_angle_knob_increment_tracker: clean");
    end else begin
      $display("tb_angle_knob_increment_tracker: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/akit_pkg.sv
rtl/core/akit_step.sv
rtl/core/angle_knob_increment_tracker.sv
tb/tb_angle_knob_increment_tracker.sv
